>>> rtl/cdt_pkg.sv
`default_nettype none

package cdt_pkg;

  // Stopwatch count width default
  localparam int unsigned WatchBitsDef = 24;

  // Time base
  localparam int unsigned SecsPerMin = 60;

  // Widths of the reported fields
  localparam int unsigned WatchMinOutBits = 19;

  // Keypad codes
  localparam logic [3:0] KeyDigitMax = 4'd9;
  localparam logic [3:0] KeyD        = 4'd13;

  // Number of digits in an MM:SS entry
  localparam logic [2:0] EntryLen = 3'd4;

  typedef enum logic [2:0] {
    CmdKey   = 3'd0,
    CmdTick  = 3'd1,
    CmdMode  = 3'd2,
    CmdStart = 3'd3,
    CmdPause = 3'd4,
    CmdReset = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ModeCalc  = 2'd0,
    ModeTimer = 2'd1,
    ModeWatch = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PhaseEntry   = 2'd0,
    PhaseCount   = 2'd1,
    PhaseTimeout = 2'd2
  } phase_e;

  // Stopwatch controls for one word
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
    logic clear;
  } watch_ctrl_t;

  // Stopwatch status after one word
  typedef struct packed {
    logic                       running;
    logic [WatchMinOutBits-1:0] minutes;
    logic [5:0]                 seconds;
  } watch_stat_t;

  // One result word
  typedef struct packed {
    logic [1:0]                 mode;
    logic [1:0]                 timer_phase;
    logic [2:0]                 entry_count;
    logic [6:0]                 entry_minutes;
    logic [6:0]                 entry_seconds;
    logic [6:0]                 remain_minutes;
    logic [5:0]                 remain_seconds;
    logic                       alarm_led;
    logic                       watch_running;
    logic [WatchMinOutBits-1:0] watch_minutes;
    logic [5:0]                 watch_seconds;
  } res_t;

  // Two decimal digits to a value: hi * 10 + lo
  function automatic logic [6:0] digit_pair(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] sum;
    sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    return sum[6:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/cdt_watch.sv
`default_nettype none

module cdt_watch #(
  parameter int unsigned WATCH_BITS = cdt_pkg::WatchBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cdt_pkg::watch_ctrl_t ctrl_i,
  output cdt_pkg::watch_stat_t      stat_o
);

  // The count is kept as minutes and seconds; minutes never reach 2^(WATCH_BITS-5)
  localparam int unsigned MinBits = WATCH_BITS - 5;
  localparam logic [WATCH_BITS-1:0] CntMax = '1;
  localparam logic [MinBits-1:0] MinMax = MinBits'(CntMax / cdt_pkg::SecsPerMin);
  localparam logic [5:0] SecMax = 6'(CntMax % cdt_pkg::SecsPerMin);
  localparam logic [5:0] SecLast = 6'(cdt_pkg::SecsPerMin - 1);

  logic               en_q, en_d;
  logic [MinBits-1:0] min_q, min_d;
  logic [5:0]         sec_q, sec_d;
  logic [MinBits+cdt_pkg::WatchMinOutBits-1:0] min_ext;

  // Advance, start, stop and clear
  always_comb begin
    en_d  = en_q;
    min_d = min_q;
    sec_d = sec_q;
    if (ctrl_i.start) begin
      en_d = 1'b1;
    end
    if (ctrl_i.stop) begin
      en_d = 1'b0;
    end
    if (ctrl_i.clear) begin
      en_d  = 1'b0;
      min_d = '0;
      sec_d = '0;
    end
    if (ctrl_i.tick && en_q) begin
      if (min_q == MinMax && sec_q == SecMax) begin
        min_d = '0;
        sec_d = '0;
      end else if (sec_q == SecLast) begin
        min_d = min_q + MinBits'(1);
        sec_d = '0;
      end else begin
        sec_d = sec_q + 6'd1;
      end
    end
  end

  // Hold the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      min_q <= '0;
      sec_q <= '0;
    end else begin
      en_q  <= en_d;
      min_q <= min_d;
      sec_q <= sec_d;
    end
  end

  // Report the status after this word
  assign min_ext = {{cdt_pkg::WatchMinOutBits{1'b0}}, min_d};
  assign stat_o.running = en_d;
  assign stat_o.minutes = min_ext[cdt_pkg::WatchMinOutBits-1:0];
  assign stat_o.seconds = sec_d;

endmodule

`default_nettype wire

>>> rtl/cdt_skid.sv
`default_nettype none

module cdt_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cdt_pkg::res_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          stall_i,
  output cdt_pkg::res_t      data_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  cdt_pkg::res_t out_q, out_d;
  cdt_pkg::res_t skid_q, skid_d;
  logic          take;

  assign take = out_valid_q && !stall_i;

  // Refill the output register from the skid stage first, park a word when blocked
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

`ifndef SYNTHESIS
  a_full_has_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a word while the output register is empty");
`endif

endmodule

`default_nettype wire

>>> rtl/countdown_timer_stopwatch.sv
`default_nettype none

// Countdown timer and stopwatch. Each input word is one event (keypad key, one-second
// tick, mode button, stopwatch start, pause or reset) and yields exactly one result word
// holding the full status after that event. The block takes one word per cycle unless
// in_stall_o is high: all state updates in a single pass of shallow logic into the state
// registers, and the result goes to an output register backed by a one-word skid stage,
// so a new word is taken even while the last result waits; in_stall_o rises only when
// both hold a word. The stopwatch keeps its count as minutes and seconds and wraps at
// 2^WATCH_BITS ticks.
module countdown_timer_stopwatch #(
  parameter int unsigned WATCH_BITS = cdt_pkg::WatchBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [3:0]  key_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       mode_o,
  output logic [1:0]       timer_phase_o,
  output logic [2:0]       entry_count_o,
  output logic [6:0]       entry_minutes_o,
  output logic [6:0]       entry_seconds_o,
  output logic [6:0]       remain_minutes_o,
  output logic [5:0]       remain_seconds_o,
  output logic             alarm_led_o,
  output logic             watch_running_o,
  output logic [18:0]      watch_minutes_o,
  output logic [5:0]       watch_seconds_o
);

  localparam logic [6:0] SecsPerMin7 = 7'(cdt_pkg::SecsPerMin);
  localparam logic [5:0] SecLast     = 6'(cdt_pkg::SecsPerMin - 1);

  logic              in_acc;
  cdt_pkg::mode_e    mode_q, mode_d;
  cdt_pkg::phase_e   phase_q, phase_d;
  logic [2:0]        idx_q, idx_d;
  logic [3:0]        digit_q [4];
  logic [3:0]        digit_d [4];
  logic [6:0]        rem_min_q, rem_min_d;
  logic [5:0]        rem_sec_q, rem_sec_d;
  logic              alarm_q, alarm_d;
  logic [6:0]        ent_min, ent_sec;
  logic              rem_zero;
  cdt_pkg::watch_ctrl_t wctrl;
  cdt_pkg::watch_stat_t wstat;
  cdt_pkg::res_t     res;
  cdt_pkg::res_t     res_out;
  logic              skid_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign ent_min  = cdt_pkg::digit_pair(digit_q[0], digit_q[1]);
  assign ent_sec  = cdt_pkg::digit_pair(digit_q[2], digit_q[3]);
  assign rem_zero = (rem_min_q == 7'd0) && (rem_sec_q == 6'd0);

  // Decode the event and advance the timer
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    digit_d   = digit_q;
    rem_min_d = rem_min_q;
    rem_sec_d = rem_sec_q;
    alarm_d   = alarm_q;
    wctrl     = '0;
    if (in_acc) begin
      unique case (cdt_pkg::cmd_e'(cmd_i))
        cdt_pkg::CmdKey: begin
          if (mode_q == cdt_pkg::ModeTimer) begin
            if (phase_q == cdt_pkg::PhaseEntry) begin
              if (key_i <= cdt_pkg::KeyDigitMax) begin
                if (idx_q >= cdt_pkg::EntryLen) begin
                  digit_d    = '{default: '0};
                  digit_d[0] = key_i;
                  idx_d      = 3'd1;
                end else begin
                  digit_d[idx_q[1:0]] = key_i;
                  idx_d               = idx_q + 3'd1;
                end
              end else if (key_i == cdt_pkg::KeyD) begin
                // Start the countdown; carry seconds of sixty or more into minutes
                phase_d = cdt_pkg::PhaseCount;
                if (ent_sec >= SecsPerMin7) begin
                  rem_min_d = ent_min + 7'd1;
                  rem_sec_d = 6'(ent_sec - SecsPerMin7);
                end else begin
                  rem_min_d = ent_min;
                  rem_sec_d = ent_sec[5:0];
                end
              end
            end else if (key_i == cdt_pkg::KeyD) begin
              // Clear the timer, and silence the alarm after a timeout
              if (phase_q == cdt_pkg::PhaseTimeout) begin
                alarm_d = 1'b0;
              end
              phase_d   = cdt_pkg::PhaseEntry;
              idx_d     = '0;
              digit_d   = '{default: '0};
              rem_min_d = '0;
              rem_sec_d = '0;
            end
          end
        end
        cdt_pkg::CmdTick: begin
          wctrl.tick = 1'b1;
          if (phase_q == cdt_pkg::PhaseCount || phase_q == cdt_pkg::PhaseTimeout) begin
            if (!rem_zero) begin
              if (rem_sec_q == 6'd0) begin
                rem_min_d = rem_min_q - 7'd1;
                rem_sec_d = SecLast;
              end else begin
                rem_sec_d = rem_sec_q - 6'd1;
              end
            end else begin
              phase_d = cdt_pkg::PhaseTimeout;
              mode_d  = cdt_pkg::ModeTimer;
              alarm_d = !alarm_q;
            end
          end
        end
        cdt_pkg::CmdMode: begin
          unique case (mode_q)
            cdt_pkg::ModeCalc:  mode_d = cdt_pkg::ModeTimer;
            cdt_pkg::ModeTimer: mode_d = cdt_pkg::ModeWatch;
            default:            mode_d = cdt_pkg::ModeCalc;
          endcase
        end
        cdt_pkg::CmdStart: wctrl.start = (mode_q == cdt_pkg::ModeWatch);
        cdt_pkg::CmdPause: wctrl.stop  = (mode_q == cdt_pkg::ModeWatch);
        cdt_pkg::CmdReset: wctrl.clear = (mode_q == cdt_pkg::ModeWatch);
        default: ;
      endcase
    end
  end

  // Hold the timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cdt_pkg::ModeCalc;
      phase_q   <= cdt_pkg::PhaseEntry;
      idx_q     <= '0;
      digit_q   <= '{default: '0};
      rem_min_q <= '0;
      rem_sec_q <= '0;
      alarm_q   <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      digit_q   <= digit_d;
      rem_min_q <= rem_min_d;
      rem_sec_q <= rem_sec_d;
      alarm_q   <= alarm_d;
    end
  end

  cdt_watch #(
    .WATCH_BITS(WATCH_BITS)
  ) u_watch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (wctrl),
    .stat_o (wstat)
  );

  // Form the result word from the state after this event
  always_comb begin
    res.mode           = mode_d;
    res.timer_phase    = phase_d;
    res.entry_count    = idx_d;
    res.entry_minutes  = cdt_pkg::digit_pair(digit_d[0], digit_d[1]);
    res.entry_seconds  = cdt_pkg::digit_pair(digit_d[2], digit_d[3]);
    res.remain_minutes = rem_min_d;
    res.remain_seconds = rem_sec_d;
    res.alarm_led      = alarm_d;
    res.watch_running  = wstat.running;
    res.watch_minutes  = wstat.minutes;
    res.watch_seconds  = wstat.seconds;
  end

  cdt_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (res),
    .full_o  (skid_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign in_stall_o       = skid_full;
  assign mode_o           = res_out.mode;
  assign timer_phase_o    = res_out.timer_phase;
  assign entry_count_o    = res_out.entry_count;
  assign entry_minutes_o  = res_out.entry_minutes;
  assign entry_seconds_o  = res_out.entry_seconds;
  assign remain_minutes_o = res_out.remain_minutes;
  assign remain_seconds_o = res_out.remain_seconds;
  assign alarm_led_o      = res_out.alarm_led;
  assign watch_running_o  = res_out.watch_running;
  assign watch_minutes_o  = res_out.watch_minutes;
  assign watch_seconds_o  = res_out.watch_seconds;

`ifndef SYNTHESIS
  a_timeout_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cdt_pkg::PhaseTimeout |-> rem_zero)
    else $error("timed out with time remaining");

  a_tick_times_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i == cdt_pkg::CmdTick && phase_q == cdt_pkg::PhaseCount && rem_zero
    |=> phase_q == cdt_pkg::PhaseTimeout && mode_q == cdt_pkg::ModeTimer)
    else $error("tick at zero did not time out");

  a_clear_silences : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i == cdt_pkg::CmdKey && key_i == cdt_pkg::KeyD
    && mode_q == cdt_pkg::ModeTimer && phase_q == cdt_pkg::PhaseTimeout
    |=> !alarm_q && phase_q == cdt_pkg::PhaseEntry && rem_zero)
    else $error("clear after timeout left the alarm or the time");

  a_remain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sec_q < 6'(cdt_pkg::SecsPerMin) && rem_min_q <= 7'd100)
    else $error("remaining time out of range");
`endif

endmodule

`default_nettype wire

>>> bench/countdown_timer_stopwatch_test.sv
`default_nettype none

module countdown_timer_stopwatch_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdt_pkg::*;

  localparam int unsigned WatchBits   = WatchBitsDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1400;
  localparam int unsigned SteadyWords = 300;
  localparam int unsigned DrainEvery  = 300;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned TailCycles  = 10;

  // Command codes the block does not define
  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  // Keypad codes without a meaning in timer entry
  localparam logic [3:0] KeyA    = 4'd10;
  localparam logic [3:0] KeyStar = 4'd14;
  localparam logic [3:0] KeyHash = 4'd15;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic [2:0] cmd_in    = CmdKey;
  logic [3:0] key_in    = 4'd0;
  logic       out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  mode;
  logic [1:0]  timer_phase;
  logic [2:0]  entry_count;
  logic [6:0]  entry_minutes;
  logic [6:0]  entry_seconds;
  logic [6:0]  remain_minutes;
  logic [5:0]  remain_seconds;
  logic        alarm_led;
  logic        watch_running;
  logic [18:0] watch_minutes;
  logic [5:0]  watch_seconds;

  // Shadow of the clock state
  mode_e                st_mode;
  phase_e               st_phase;
  logic [2:0]           st_idx;
  logic [3:0]           st_dig [4];
  int unsigned          st_remain;
  logic                 st_alarm;
  logic                 st_wen;
  logic [WatchBits-1:0] st_wcount;

  res_t status_q [$];

  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  int unsigned rx_hold_len = 0;

  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  countdown_timer_stopwatch #(
    .WATCH_BITS(WatchBits)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd_in),
    .key_i           (key_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .mode_o          (mode),
    .timer_phase_o   (timer_phase),
    .entry_count_o   (entry_count),
    .entry_minutes_o (entry_minutes),
    .entry_seconds_o (entry_seconds),
    .remain_minutes_o(remain_minutes),
    .remain_seconds_o(remain_seconds),
    .alarm_led_o     (alarm_led),
    .watch_running_o (watch_running),
    .watch_minutes_o (watch_minutes),
    .watch_seconds_o (watch_seconds)
  );

  // Generate the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drop the timer back to an empty entry
  function automatic void clear_entry();
    st_phase  = PhaseEntry;
    st_idx    = 3'd0;
    st_dig[0] = 4'd0;
    st_dig[1] = 4'd0;
    st_dig[2] = 4'd0;
    st_dig[3] = 4'd0;
    st_remain = 0;
  endfunction

  // Advance the shadow state by one event and form the status it reports
  task automatic apply_event(input logic [2:0] cmd, input logic [3:0] key,
                             output res_t status);
    int unsigned mm, ss;
    case (cmd)
      CmdKey: begin
        if (st_mode == ModeTimer) begin
          if (st_phase == PhaseEntry) begin
            if (key <= KeyDigitMax) begin
              // a fifth digit restarts the entry
              if (st_idx >= EntryLen) clear_entry();
              st_dig[st_idx[1:0]] = key;
              st_idx = st_idx + 3'd1;
            end else if (key == KeyD) begin
              mm        = st_dig[0] * 10 + st_dig[1];
              ss        = st_dig[2] * 10 + st_dig[3];
              st_remain = mm * SecsPerMin + ss;
              st_phase  = PhaseCount;
            end
          end else if (key == KeyD) begin
            if (st_phase == PhaseTimeout) st_alarm = 1'b0;
            clear_entry();
          end
        end
      end
      CmdTick: begin
        if (st_wen) st_wcount = st_wcount + 1'b1;
        if (st_phase != PhaseEntry) begin
          if (st_remain > 0) begin
            st_remain = st_remain - 1;
          end else begin
            // timeout forces timer mode and toggles the alarm
            st_phase = PhaseTimeout;
            st_mode  = ModeTimer;
            st_alarm = ~st_alarm;
          end
        end
      end
      CmdMode:  st_mode = (st_mode == ModeWatch) ? ModeCalc : mode_e'(st_mode + 2'd1);
      CmdStart: if (st_mode == ModeWatch) st_wen = 1'b1;
      CmdPause: if (st_mode == ModeWatch) st_wen = 1'b0;
      CmdReset: begin
        if (st_mode == ModeWatch) begin
          st_wen    = 1'b0;
          st_wcount = '0;
        end
      end
      default: ;
    endcase

    mm = st_dig[0] * 10 + st_dig[1];
    ss = st_dig[2] * 10 + st_dig[3];
    status.mode           = st_mode;
    status.timer_phase    = st_phase;
    status.entry_count    = st_idx;
    status.entry_minutes  = 7'(mm);
    status.entry_seconds  = 7'(ss);
    status.remain_minutes = 7'(st_remain / SecsPerMin);
    status.remain_seconds = 6'(st_remain % SecsPerMin);
    status.alarm_led      = st_alarm;
    status.watch_running  = st_wen;
    status.watch_minutes  = 19'(st_wcount / SecsPerMin);
    status.watch_seconds  = 6'(st_wcount % SecsPerMin);
  endtask

  // Offer one event word, hold it until taken, then record its status
  task automatic send_word(input logic [2:0] cmd, input logic [3:0] key);
    res_t status;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_in   <= cmd;
    key_in   <= key;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    apply_event(cmd, key, status);
    status_q.push_back(status);
    words_sent++;
  endtask

  // Hold off input until every pending status has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic goto_mode(input mode_e target);
    while (st_mode != target) send_word(CmdMode, 4'($urandom_range(0, 15)));
  endtask

  // Enter MM:SS, start the countdown and tick it out, mostly to a timeout
  task automatic run_countdown();
    int unsigned n_digits, n_ticks;
    bit          short_entry;
    logic [3:0]  digit;
    goto_mode(ModeTimer);
    if (st_phase != PhaseEntry) send_word(CmdKey, KeyD);
    n_digits    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 4;
    short_entry = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < n_digits; i++) begin
      if (!short_entry || i == 3) digit = 4'($urandom_range(0, 9));
      else if (i == 2) digit = 4'($urandom_range(0, 1));
      else digit = 4'd0;
      send_word(CmdKey, digit);
      // stray non-digit key now and then
      if ($urandom_range(0, 9) == 0) send_word(CmdKey, 4'($urandom_range(10, 15)));
    end
    send_word(CmdKey, KeyD);
    n_ticks = (st_remain <= 150) ? st_remain + $urandom_range(1, 4) : $urandom_range(1, 20);
    for (int i = 0; i < n_ticks; i++) begin
      send_word(CmdTick, 4'($urandom_range(0, 15)));
      // mode and stopwatch buttons in the middle of a countdown
      if ($urandom_range(0, 11) == 0) begin
        send_word(3'($urandom_range(2, 4)), 4'($urandom_range(0, 15)));
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      goto_mode(ModeTimer);
      send_word(CmdKey, KeyD);
    end
  endtask

  // Run the stopwatch with a random mix of its buttons
  task automatic run_stopwatch();
    int unsigned n_events, pick;
    goto_mode(ModeWatch);
    send_word(CmdStart, 4'($urandom_range(0, 15)));
    n_events = $urandom_range(1, 40);
    for (int i = 0; i < n_events; i++) begin
      pick = $urandom_range(0, 15);
      if (pick < 11) send_word(CmdTick, 4'($urandom_range(0, 15)));
      else if (pick == 11) send_word(CmdPause, 4'($urandom_range(0, 15)));
      else if (pick == 12) send_word(CmdStart, 4'($urandom_range(0, 15)));
      else if (pick == 13) send_word(CmdReset, 4'($urandom_range(0, 15)));
      else if (pick == 14) send_word(CmdMode, 4'($urandom_range(0, 15)));
      else send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    end
  endtask

  // Mix countdowns, stopwatch runs and raw noise words
  task automatic random_mix(input int unsigned count);
    int unsigned target, next_drain, pick;
    target     = words_sent + count;
    next_drain = words_sent + DrainEvery;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        run_countdown();
      end else if (pick < 8) begin
        run_stopwatch();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end
      end
      if (tx_idle_en && words_sent >= next_drain) begin
        wait_for_results();
        next_drain = words_sent + DrainEvery;
      end
    end
  endtask

  task automatic test_ignored_events();
    send_word(CmdKey, 4'd5);
    send_word(CmdStart, 4'd0);
    send_word(CmdReset, KeyHash);
    send_word(CmdSpareLo, 4'd0);
    send_word(CmdSpareHi, KeyHash);
  endtask

  task automatic test_timer_entry();
    goto_mode(ModeTimer);
    repeat (4) send_word(CmdKey, 4'd9);
    send_word(CmdKey, KeyStar);
    send_word(CmdKey, KeyA);
    // fifth digit restarts the entry as 10:00
    send_word(CmdKey, 4'd1);
    send_word(CmdKey, KeyD);
    send_word(CmdTick, 4'd0);
    send_word(CmdKey, 4'd5);
    // clear while counting
    send_word(CmdKey, KeyD);
  endtask

  task automatic test_timeout_alarm();
    // zero entry times out on the first tick
    send_word(CmdKey, KeyD);
    send_word(CmdTick, 4'd0);
    send_word(CmdTick, 4'd0);
    send_word(CmdMode, 4'd0);
    // a tick in stopwatch mode pulls back to timer mode
    send_word(CmdTick, KeyHash);
    send_word(CmdKey, 4'd7);
    send_word(CmdKey, KeyD);
  endtask

  task automatic test_stopwatch_buttons();
    goto_mode(ModeWatch);
    send_word(CmdStart, 4'd0);
    send_word(CmdTick, 4'd0);
    send_word(CmdTick, 4'd0);
    send_word(CmdPause, 4'd0);
    send_word(CmdTick, 4'd0);
    send_word(CmdStart, 4'd0);
    // count keeps going in calculator mode
    send_word(CmdMode, 4'd0);
    send_word(CmdTick, 4'd0);
    goto_mode(ModeWatch);
    send_word(CmdReset, 4'd0);
  endtask

  task automatic test_random_events();
    random_mix(RandomWords);
  endtask

  task automatic test_back_pressure();
    tx_idle_en  = 1'b0;
    rx_hold_len = HoldCycles;
    repeat (40) send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    tx_idle_en = 1'b1;
    wait_for_results();
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_mix(SteadyWords);
  endtask

  // Compare one field of a status word
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Check each accepted status word against the oldest prediction
  always @(posedge clk_i) begin : status_checker
    res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("status word with no pending prediction");
        error_count++;
      end else begin
        want = status_q.pop_front();
        check_field("mode", want.mode, mode);
        check_field("timer_phase", want.timer_phase, timer_phase);
        check_field("entry_count", want.entry_count, entry_count);
        check_field("entry_minutes", want.entry_minutes, entry_minutes);
        check_field("entry_seconds", want.entry_seconds, entry_seconds);
        check_field("remain_minutes", want.remain_minutes, remain_minutes);
        check_field("remain_seconds", want.remain_seconds, remain_seconds);
        check_field("alarm_led", want.alarm_led, alarm_led);
        check_field("watch_running", want.watch_running, watch_running);
        check_field("watch_minutes", want.watch_minutes, watch_minutes);
        check_field("watch_seconds", want.watch_seconds, watch_seconds);
        words_checked++;
      end
    end
  end

  // Stall the output side: a long hold on request, else random bursts
  initial begin : out_stall_gen
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** countdown_timer_stopwatch: FAILED **");
    $finish;
  end

  initial begin : run_tests
    st_mode   = ModeCalc;
    st_alarm  = 1'b0;
    st_wen    = 1'b0;
    st_wcount = '0;
    clear_entry();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_events();
    test_timer_entry();
    test_timeout_alarm();
    test_stopwatch_buttons();
    wait_for_results();
    test_random_events();
    test_back_pressure();
    test_steady_stream();

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d event words, checked %0d status words (%0d errors).",
             words_sent, words_checked, error_count);
    $display("Covered timer entry, countdown, timeout alarm, stopwatch, and a long output hold.");
    if (error_count == 0) begin
      $display("** countdown_timer_stopwatch: PASSED **");
    end else begin
      $display("** countdown_timer_stopwatch: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
